[rtl/mcdt_pkg.sv]
package mcdt_pkg;

  localparam int unsigned MaxChannels     = 8;
  localparam int unsigned DefChannels     = 8;
  localparam int unsigned DefCountWidth   = 32;
  localparam int unsigned DataWidth       = 32;
  localparam int unsigned ModeWidth       = 2;
  localparam int unsigned ChannelSelWidth = 3;
  localparam int unsigned RegSelWidth     = 3;
  localparam int unsigned CtlWidth        = 3;

  // control register bit positions
  localparam int unsigned CtlEnableBit   = 0;
  localparam int unsigned CtlPeriodicBit = 1;
  localparam int unsigned CtlMaskBit     = 2;

  typedef enum logic [ModeWidth-1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [RegSelWidth-1:0] {
    REG_LOAD    = 3'd0,
    REG_CURRENT = 3'd1,
    REG_CONTROL = 3'd2,
    REG_EOI     = 3'd3,
    REG_STATUS  = 3'd4
  } reg_sel_e;

  // command seen by every channel for the word being processed
  typedef struct packed {
    logic     advance;
    mode_e    mode;
    reg_sel_e sel;
  } mcdt_cmd_t;

endpackage

[rtl/mcdt_channel.sv]
module mcdt_channel #(
  parameter int unsigned COUNT_WIDTH = mcdt_pkg::DefCountWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcdt_pkg::mcdt_cmd_t           cmd_i,
  input  logic                          hit_i,
  input  logic                          tick_i,
  input  logic [mcdt_pkg::DataWidth-1:0] wdata_i,
  output logic [mcdt_pkg::DataWidth-1:0] rdata_o,
  output logic                          irq_o
);

  logic [COUNT_WIDTH-1:0]          load_q, load_d;
  logic [COUNT_WIDTH-1:0]          count_q, count_d;
  logic [mcdt_pkg::CtlWidth-1:0]   ctrl_q, ctrl_d;
  logic                            status_q, status_d;

  // register value as seen before this word's update
  always_comb begin
    unique case (cmd_i.sel)
      mcdt_pkg::REG_LOAD:    rdata_o = mcdt_pkg::DataWidth'(load_q);
      mcdt_pkg::REG_CURRENT: rdata_o = mcdt_pkg::DataWidth'(count_q);
      mcdt_pkg::REG_CONTROL: rdata_o = mcdt_pkg::DataWidth'(ctrl_q);
      mcdt_pkg::REG_STATUS:
        rdata_o = mcdt_pkg::DataWidth'(status_q & ~ctrl_q[mcdt_pkg::CtlMaskBit]);
      default:               rdata_o = '0;
    endcase
  end

  always_comb begin
    load_d   = load_q;
    count_d  = count_q;
    ctrl_d   = ctrl_q;
    status_d = status_q;
    if (cmd_i.advance) begin
      unique case (cmd_i.mode)
        mcdt_pkg::MODE_TICK: begin
          if (tick_i && ctrl_q[mcdt_pkg::CtlEnableBit]) begin
            if (count_q == '0) begin
              count_d  = ctrl_q[mcdt_pkg::CtlPeriodicBit] ? load_q : '1;
              status_d = 1'b1;
            end else begin
              count_d = count_q - COUNT_WIDTH'(1);
            end
          end
        end
        mcdt_pkg::MODE_READ: begin
          // reading end-of-interrupt acknowledges
          if (hit_i && cmd_i.sel == mcdt_pkg::REG_EOI) begin
            status_d = 1'b0;
          end
        end
        mcdt_pkg::MODE_WRITE: begin
          if (hit_i && cmd_i.sel == mcdt_pkg::REG_LOAD) begin
            load_d = wdata_i[COUNT_WIDTH-1:0];
          end else if (hit_i && cmd_i.sel == mcdt_pkg::REG_CONTROL) begin
            // rising enable starts from the load count
            if (wdata_i[mcdt_pkg::CtlEnableBit] && !ctrl_q[mcdt_pkg::CtlEnableBit]) begin
              count_d = load_q;
            end
            ctrl_d = wdata_i[mcdt_pkg::CtlWidth-1:0];
          end
        end
        mcdt_pkg::MODE_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign irq_o = status_d & ~ctrl_d[mcdt_pkg::CtlMaskBit];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q   <= '1;
      count_q  <= '0;
      ctrl_q   <= '0;
      status_q <= 1'b0;
    end else begin
      load_q   <= load_d;
      count_q  <= count_d;
      ctrl_q   <= ctrl_d;
      status_q <= status_d;
    end
  end

endmodule

[rtl/multi_channel_down_timer.sv]
// Bank of CHANNELS down-counting timers, each COUNT_WIDTH bits wide, driven
// by a single word stream: a tick word decrements every enabled channel whose
// tick_mask bit is set (a channel at zero reloads instead, from its load count
// in periodic mode or from all ones in free-running mode, and raises status);
// read and write words reach the load, current, control, end-of-interrupt and
// status registers of the channel addressed. Every word returns exactly one
// result word carrying read data (zero unless it answers a read), read_valid,
// and the interrupt lines after that word's update. One word is taken every
// clock cycle while the consumer keeps up; a taken word is held in the input
// register, then passes through the per-channel update logic into the result
// register. A result held by a stalled consumer still lets one more word into
// the input register; the input stalls only while both registers hold a word
// and the consumer is not ready.
module multi_channel_down_timer #(
  parameter int unsigned CHANNELS    = mcdt_pkg::DefChannels,
  parameter int unsigned COUNT_WIDTH = mcdt_pkg::DefCountWidth
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [mcdt_pkg::ModeWidth-1:0]        mode_i,
  input  logic [mcdt_pkg::ChannelSelWidth-1:0]  channel_i,
  input  logic [mcdt_pkg::RegSelWidth-1:0]      reg_select_i,
  input  logic [mcdt_pkg::DataWidth-1:0]        write_data_i,
  input  logic [mcdt_pkg::MaxChannels-1:0]      tick_mask_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mcdt_pkg::DataWidth-1:0]        read_data_o,
  output logic                                  read_valid_o,
  output logic [mcdt_pkg::MaxChannels-1:0]      irq_lines_o
);

  // input register
  logic                                 in_valid_q;
  logic [mcdt_pkg::ModeWidth-1:0]       mode_q;
  logic [mcdt_pkg::ChannelSelWidth-1:0] channel_q;
  logic [mcdt_pkg::RegSelWidth-1:0]     sel_q;
  logic [mcdt_pkg::DataWidth-1:0]       wdata_q;
  logic [mcdt_pkg::MaxChannels-1:0]     tick_q;

  // result register
  logic                                 out_valid_q;
  logic [mcdt_pkg::DataWidth-1:0]       read_data_q, read_data_d;
  logic                                 read_valid_q, read_valid_d;
  logic [mcdt_pkg::MaxChannels-1:0]     irq_lines_q, irq_lines_d;

  logic                                 advance;
  mcdt_pkg::mcdt_cmd_t                  cmd;
  logic [mcdt_pkg::DataWidth-1:0]       ch_rdata [CHANNELS];
  logic [CHANNELS-1:0]                  ch_irq;
  logic [mcdt_pkg::DataWidth-1:0]       rd_mux;

  // the held word moves into the result register when that slot frees up
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign cmd.advance = advance;
  assign cmd.mode    = mcdt_pkg::mode_e'(mode_q);
  assign cmd.sel     = mcdt_pkg::reg_sel_e'(sel_q);

  for (genvar n = 0; n < CHANNELS; n++) begin : g_chan
    mcdt_channel #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_chan (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .hit_i   (channel_q == mcdt_pkg::ChannelSelWidth'(n)),
      .tick_i  (tick_q[n]),
      .wdata_i (wdata_q),
      .rdata_o (ch_rdata[n]),
      .irq_o   (ch_irq[n])
    );
  end

  // read mux: at most one channel matches, out-of-range channels read zero
  always_comb begin
    rd_mux = '0;
    for (int n = 0; n < CHANNELS; n++) begin
      if (channel_q == mcdt_pkg::ChannelSelWidth'(n)) begin
        rd_mux = rd_mux | ch_rdata[n];
      end
    end
  end

  assign read_valid_d = (cmd.mode == mcdt_pkg::MODE_READ);
  assign read_data_d  = read_valid_d ? rd_mux : '0;
  // lines above the bank stay low
  assign irq_lines_d  = mcdt_pkg::MaxChannels'(ch_irq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mode_q    <= mode_i;
      channel_q <= channel_i;
      sel_q     <= reg_select_i;
      wdata_q   <= write_data_i;
      tick_q    <= tick_mask_i;
    end
    if (advance) begin
      read_data_q  <= read_data_d;
      read_valid_q <= read_valid_d;
      irq_lines_q  <= irq_lines_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = read_data_q;
  assign read_valid_o = read_valid_q;
  assign irq_lines_o  = irq_lines_q;

`ifndef SYNTHESIS
  // a held word that cannot move stays held
  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input word lost while stalled");

  // a word that moves always lands in the result register
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result missing after advance");

  // back-pressure only when both stages are full and the consumer stalls
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without cause");

  // non-read results carry zero data
  a_rdata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_data_o == '0)
    else $error("read data on a non-read result");
`endif

endmodule
